>>> src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while rst_n is low.
`define FRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while rst_n is low.
`define FRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define FRS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/frs_pkg.sv
// Shared types and constants of the frame RMS error block.
package frs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 17;
  localparam int RMS_W    = 16;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int ITER_W   = $clog2(SUM_W);

  localparam logic [CNT_W-1:0]  FRAME_CAP = CNT_W'(65536);
  localparam logic [CNT_W-1:0]  MAX_ITEMS = CNT_W'(65536);
  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(SUM_W - 1);
  localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(ROOT_W - 1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_SQINIT,
    ST_SQRT,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic div_en;
    logic sqrt_load;
    logic sqrt_en;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic iter_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> src/frs_ctrl.sv
// Controller state machine: accumulate, divide, square root, hand over.
module frs_ctrl
  import frs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && stat.emit) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (stat.iter_last) begin
          state_nxt = ST_SQINIT;
        end
      end
      ST_SQINIT: begin
        cmd.sqrt_load = 1'b1;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_en = 1'b1;
        if (stat.iter_last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

endmodule

>>> src/frs_dp.sv
// Datapath: squared difference pipeline, accumulator, divider, square root, output register.
module frs_dp
  import frs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CNT_W-1:0]      cfg_wr_data,
  input  logic [2*SAMPLE_W-1:0] in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RMS_W-1:0]      out_tdata,
  output logic                  out_tuser,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat
);

  logic [CNT_W-1:0]  frame_len_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [SQ_W-1:0]   sq_r;
  logic              pend_v_r;
  logic              pend_add_r;
  logic              pend_clr_r;
  logic [CNT_W-1:0]  den_r;
  logic              res_ovf_r;
  logic [SUM_W-1:0]  div_q_r;
  logic [CNT_W-1:0]  div_rem_r;
  logic [REM_W-1:0]  sq_rem_r;
  logic [ROOT_W-1:0] sq_root_r;
  logic [ITER_W-1:0] iter_r;
  logic              out_valid_r;
  logic [RMS_W-1:0]  out_data_r;
  logic              out_user_r;

  logic signed [DIFF_W-1:0] samp_a;
  logic signed [DIFF_W-1:0] samp_b;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        abs_diff;
  logic [SQ_W-1:0]          sq;
  logic [CNT_W-1:0]         flen;
  logic                     frame_mode;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     full;
  logic                     take;
  logic                     emit;
  logic                     clr;
  logic [SUM_W-1:0]         sum_new;
  logic [CNT_W:0]           div_tmp;
  logic                     div_ge;
  logic [CNT_W:0]           div_diff;
  logic [REM_W+1:0]         sq_tmp;
  logic [REM_W+1:0]         sq_trial;
  logic                     sq_ge;
  logic [REM_W+1:0]         sq_diff;
  logic [RMS_W-1:0]         rms;

  // Squared difference of the incoming pair.
  always_comb begin
    samp_a   = DIFF_W'(signed'(in_tdata[SAMPLE_W-1:0]));
    samp_b   = DIFF_W'(signed'(in_tdata[2*SAMPLE_W-1:SAMPLE_W]));
    diff     = samp_a - samp_b;
    abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq       = SQ_W'(abs_diff) * SQ_W'(abs_diff);
  end

  // Frame bookkeeping for the item on offer.
  always_comb begin
    flen       = (frame_len_r > FRAME_CAP) ? FRAME_CAP : frame_len_r;
    frame_mode = (flen != '0);
    cnt_inc    = cnt_r + CNT_W'(1);
    full       = (cnt_r >= MAX_ITEMS);
    take       = frame_mode || !full;
    emit       = frame_mode ? (cnt_inc >= flen) : in_tlast;
    clr        = emit || in_tlast;
    sum_new    = sum_r + (pend_add_r ? SUM_W'(sq_r) : '0);
  end

  // One restoring divide step and one square root step.
  always_comb begin
    div_tmp  = {div_rem_r, div_q_r[SUM_W-1]};
    div_ge   = (div_tmp >= {1'b0, den_r});
    div_diff = div_tmp - {1'b0, den_r};
    sq_tmp   = {sq_rem_r, div_q_r[SUM_W-1:SUM_W-2]};
    sq_trial = {2'b00, sq_root_r, 2'b01};
    sq_ge    = (sq_tmp >= sq_trial);
    sq_diff  = sq_tmp - sq_trial;
  end

  // Saturated result, zero for an empty count.
  always_comb begin
    if (den_r == '0) begin
      rms = '0;
    end else if (sq_root_r[ROOT_W-1:RMS_W] != '0) begin
      rms = '1;
    end else begin
      rms = sq_root_r[RMS_W-1:0];
    end
  end

  assign stat.emit      = emit;
  assign stat.iter_last = (iter_r == '0);
  assign stat.out_free  = !out_valid_r || out_tready;

  // Accumulator and the one-stage pipeline behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      pend_add_r  <= 1'b0;
      pend_clr_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      frame_len_r <= cfg_wr_data;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (pend_v_r) begin
        sum_r <= pend_clr_r ? '0 : sum_new;
      end
      pend_v_r <= cmd.accept;
      if (cmd.accept) begin
        pend_add_r <= take;
        pend_clr_r <= clr;
        if (clr) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else if (take) begin
          cnt_r <= cnt_inc;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // Payload of the pipeline and the frame snapshot.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq_r <= sq;
      if (emit) begin
        den_r     <= take ? cnt_inc : cnt_r;
        res_ovf_r <= !frame_mode && (ovf_r || full);
      end
    end
  end

  // Divider and square root share the quotient register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_q_r   <= sum_new;
      div_rem_r <= '0;
    end else if (cmd.div_en) begin
      div_q_r   <= {div_q_r[SUM_W-2:0], div_ge};
      div_rem_r <= div_ge ? div_diff[CNT_W-1:0] : div_tmp[CNT_W-1:0];
    end else if (cmd.sqrt_en) begin
      div_q_r <= {div_q_r[SUM_W-3:0], 2'b00};
    end
    if (cmd.sqrt_load) begin
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.sqrt_en) begin
      sq_rem_r  <= sq_ge ? sq_diff[REM_W-1:0] : sq_tmp[REM_W-1:0];
      sq_root_r <= {sq_root_r[ROOT_W-2:0], sq_ge};
    end
  end

  // Step counter for both iterative units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.load) begin
      iter_r <= DIV_LAST;
    end else if (cmd.sqrt_load) begin
      iter_r <= ROOT_LAST;
    end else if (cmd.div_en || cmd.sqrt_en) begin
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= rms;
      out_user_r <= res_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> src/frame_rms_error.sv
// Top level of the frame RMS error block.
//
//  channel   direction  tdata                          tuser       tlast
//  in_       in         [15:0] sample_a, [31:16] b     -           end_of_stream
//  out_      out        [15:0] rms_error               overflowed  -
//  cfg_      in         [16:0] frame_length (write)    -           -
//
// A pair is taken every cycle while a frame is open. At the end of a frame
// the block stops taking items through one load, 48 divide steps,
// one root set-up, 24 root steps and one hand-over to the output register.
// The hand-over waits while an earlier result is still held at the output.
// Reset is synchronous and active low; it clears the frame length and sums.
module frame_rms_error
  import frs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CNT_W-1:0]      cfg_wr_data,   // frame_length
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*SAMPLE_W-1:0] in_tdata,      // sample_a, sample_b
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RMS_W-1:0]      out_tdata,     // rms_error
  output logic                  out_tuser      // overflowed
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  frs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

>>> src/frs_checker.sv
// Port-level checker for the frame RMS error block, bound to the top level.
`include "assert_macros.svh"

module frs_checker
  import frs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [RMS_W-1:0] out_tdata,
  input logic             out_tuser
);

  logic out_stall;

  // A result on offer that the receiver does not take this cycle.
  assign out_stall = out_tvalid && !out_tready;

  // Reset leaves no result on offer.
  `FRS_ASSERT_NEXT_ALWAYS(a_rst_empty, !rst_n, !out_tvalid, "result offered after reset")

  // A new result only appears after the back end has held off input.
  `FRS_ASSERT_NOW(a_rise_after_hold, $rose(out_tvalid), !$past(in_tready), "no hold-off")

  // A stalled result stays on offer.
  `FRS_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "result dropped while stalled")

  // A stalled result keeps its value.
  `FRS_ASSERT_NEXT(a_out_stable, out_stall, $stable({out_tdata, out_tuser}), "result changed")

endmodule

bind frame_rms_error frs_checker u_frs_checker (.*);

>>> test/tb_frame_rms_error.sv
`timescale 1ns / 100ps
// Self-checking testbench of the frame RMS error block, driven by directed and random streams of sample pairs.
module tb_frame_rms_error;
  import frs_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS  = 1250;

  // Which side of the stream idles, in the order the run goes through them.
  typedef enum int {
    IDLE_RECV_HEAVY,
    IDLE_SEND_HEAVY,
    IDLE_OFF
  } idle_plan_t;

  typedef struct {
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic                eos;
  } pair_t;

  typedef struct {
    logic [RMS_W-1:0] rms;
    logic             ovf;
  } rms_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2*SAMPLE_W-1:0] in_tdata = '0;     // sample_a, sample_b
  logic                  in_tlast = 1'b0;   // end_of_stream
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RMS_W-1:0]      out_tdata;         // rms_error
  logic                  out_tuser;         // overflowed

  // Predicted state of the block.
  logic [CNT_W-1:0] frame_length_reg = '0;
  logic [SUM_W-1:0] sum_sq = '0;
  logic [CNT_W-1:0] pair_count = '0;
  logic             capacity_hit = 1'b0;

  pair_t       pairs_to_send[$];
  rms_result_t rms_expected[$];
  pair_t       next_pair;
  rms_result_t want;
  int          pairs_queued = 0;
  int          pairs_accepted = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  frame_rms_error DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Floor root of the floor mean, saturated to the output width.
  function automatic logic [RMS_W-1:0] floor_rms(logic [SUM_W-1:0] total,
                                                 logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] mean;
    logic [SUM_W-1:0] root;
    logic [SUM_W-1:0] trial;
    if (n == 0) return '0;
    mean = total / n;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = root | (SUM_W'(1) << i);
      if (trial * trial <= mean) root = trial;
    end
    if (root > SUM_W'({RMS_W{1'b1}})) return {RMS_W{1'b1}};
    return root[RMS_W-1:0];
  endfunction

  function automatic void clear_sums();
    sum_sq = '0;
    pair_count = '0;
    capacity_hit = 1'b0;
  endfunction

  // Updates the predicted state for one accepted pair and queues any result it causes.
  function automatic void predict_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                       logic eos);
    longint           diff;
    logic [SUM_W-1:0] sq;
    logic [CNT_W-1:0] flen;
    diff = longint'($signed(a)) - longint'($signed(b));
    sq = SUM_W'(diff * diff);
    flen = (frame_length_reg > FRAME_CAP) ? FRAME_CAP : frame_length_reg;
    if (flen != 0) begin
      sum_sq = sum_sq + sq;
      pair_count = pair_count + 1'b1;
      if (pair_count >= flen) begin
        rms_expected.push_back('{floor_rms(sum_sq, pair_count), 1'b0});
        clear_sums();
      end else if (eos) begin
        // A partial frame is dropped without a result.
        clear_sums();
      end
    end else begin
      // Whole-stream mode: pairs beyond capacity are ignored but flagged.
      if (pair_count >= MAX_ITEMS) begin
        capacity_hit = 1'b1;
      end else begin
        sum_sq = sum_sq + sq;
        pair_count = pair_count + 1'b1;
      end
      if (eos) begin
        rms_expected.push_back('{floor_rms(sum_sq, pair_count), capacity_hit});
        clear_sums();
      end
    end
  endfunction

  // Sender: a new item is offered once the previous one has gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_tready) begin
        if (pairs_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair = pairs_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {next_pair.b, next_pair.a};
          in_tlast  <= next_pair.eos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each accepted input item and checks each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_pair(in_tdata[SAMPLE_W-1:0], in_tdata[2*SAMPLE_W-1:SAMPLE_W], in_tlast);
        pairs_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (rms_expected.size() == 0) begin
          $display("%0t: result with none expected: rms_error %0d overflowed %0b",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = rms_expected.pop_front();
          if (out_tdata !== want.rms) begin
            $display("%0t: rms_error expected %0d, actual %0d", $time, want.rms, out_tdata);
            mismatch_count++;
          end
          if (out_tuser !== want.ovf) begin
            $display("%0t: overflowed expected %0b, actual %0b", $time, want.ovf, out_tuser);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_idling(idle_plan_t plan);
    case (plan)
      IDLE_RECV_HEAVY: begin
        send_idle_pct = 27;
        recv_idle_pct = 52;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 52;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic add_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b, logic eos);
    pairs_to_send.push_back('{a, b, eos});
    pairs_queued++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(16)) - SAMPLE_W'(8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Either two unrelated samples or a pair that differs only a little.
  task automatic add_random_pair(logic eos);
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    a = rand_sample();
    if ($urandom_range(3) == 0) b = a + SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
    else b = rand_sample();
    add_pair(a, b, eos);
  endtask

  // Waits until every item is taken and every result is back, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    while (pairs_queued != pairs_accepted || rms_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A write also clears the sums, both in the block and in the prediction.
  task automatic write_frame_length(logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    frame_length_reg = value;
    clear_sums();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int flen;
    int phase_start;
    int runs;
    int run_len;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_RECV_HEAVY);

    // Directed: extremes in whole-stream mode, ended by the last-item mark.
    write_frame_length(0);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    add_pair(16'h8000, 16'h7FFF, 1'b0);
    add_pair(16'h0000, 16'h0000, 1'b0);
    add_pair(16'hFFFF, 16'h0001, 1'b1);
    drain();

    // One-item frames, including a mark on the completing item.
    write_frame_length(1);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    add_pair(16'h8000, 16'h8000, 1'b1);
    add_pair(16'h1234, 16'h0FFF, 1'b0);
    drain();

    // A partial frame dropped by the mark, a full one completed on it, then a leftover.
    write_frame_length(3);
    add_pair(16'h0100, 16'hFF00, 1'b0);
    add_pair(16'h7FFF, 16'h0000, 1'b1);
    add_pair(16'h0005, 16'h0002, 1'b0);
    add_pair(16'hFFF0, 16'h0010, 1'b0);
    add_pair(16'h8000, 16'h0000, 1'b1);
    add_pair(16'h4000, 16'hC000, 1'b0);
    add_pair(16'h0001, 16'h0000, 1'b0);
    drain();

    // Oversized and largest frame lengths; the write in between clears the sums.
    write_frame_length(17'h1FFFF);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    add_pair(16'h0003, 16'h0007, 1'b0);
    add_pair(16'h2222, 16'h1111, 1'b1);
    drain();
    write_frame_length(17'h10000);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    add_pair(16'h7FFF, 16'h8000, 1'b0);
    drain();
    write_frame_length(2);
    add_pair(16'h0009, 16'h0000, 1'b0);
    add_pair(16'h0000, 16'h0003, 1'b0);
    drain();

    // Random: each idling plan in turn, over phases of varied frame length.
    for (int plan = 0; plan < 3; plan++) begin
      set_idling(idle_plan_t'(plan));
      phase_start = pairs_queued;
      while (pairs_queued - phase_start < RANDOM_ITEMS / 3) begin
        case ($urandom_range(4))
          0:       flen = 0;
          1:       flen = 1;
          2:       flen = $urandom_range(2, 4);
          3:       flen = $urandom_range(5, 40);
          default: flen = $urandom_range(2, 12);
        endcase
        write_frame_length(CNT_W'(flen));
        if (flen == 0) begin
          // Well-formed streams with random content, sometimes a trailing open one.
          runs = $urandom_range(2, 6);
          for (int r = 0; r < runs; r++) begin
            run_len = $urandom_range(1, 24);
            for (int k = 0; k < run_len; k++) add_random_pair(k == run_len - 1);
          end
          if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) add_random_pair(1'b0);
          end
        end else begin
          // Frames with the odd stray last-item mark.
          n = $urandom_range(flen, 3 * flen + 2);
          for (int k = 0; k < n; k++) add_random_pair($urandom_range(24) == 0);
        end
        drain();
      end
    end

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/frs_pkg.sv
src/frs_ctrl.sv
src/frs_dp.sv
src/frame_rms_error.sv
src/frs_checker.sv
test/tb_frame_rms_error.sv
